@@ design/tsms_pkg.sv @@
`default_nettype none

package tsms_pkg;

    // Default sizes of the matrix and of the entry store.
    localparam int DEF_MAX_DIM     = 1024;
    localparam int DEF_MAX_ENTRIES = 4096;

    // Field widths of the stream words.
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;
    localparam int VAL_W  = 16;
    localparam int STAT_W = 2;

    // Input tdata: row, col, cell_value packed from bit 0, padded to 40 bits.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    // Row entry count saturates at this value.
    localparam int               LEN_W   = 11;
    localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

    // Configuration registers.
    localparam int CNT_W      = 11;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD = 2'd2;

    localparam logic [CNT_W-1:0] RST_ROW_COUNT      = 11'd1024;
    localparam logic [CNT_W-1:0] RST_COL_COUNT      = 11'd1024;
    localparam logic [THR_W-1:0] RST_KEEP_THRESHOLD = 16'd328;

    // Word kinds carried in the input tuser.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Lookup status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_HIT    = 2'd0,
        ST_ABSENT = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_QROW,
        S_QCMP,
        S_PUT
    } t_state;

    // Conditions reported by the datapath to the sequencer.
    typedef struct packed {
        logic accept;
        logic kind;
        logic row_stop;
        logic cmp_stop;
        logic out_free;
    } t_seq_stat;

    // Controls driven by the sequencer.
    typedef struct packed {
        logic ready;
        logic ld_commit;
        logic q_row;
        logic q_cmp;
        logic put;
    } t_seq_ctrl;

endpackage

`default_nettype wire

@@ design/tsms_ram.sv @@
`default_nettype none

module tsms_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/tsms_seq.sv @@
`default_nettype none

module tsms_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tsms_pkg::t_seq_stat i_stat,
    output tsms_pkg::t_seq_ctrl      o_ctrl,
    output tsms_pkg::t_state         o_state
);

    import tsms_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a load commits and returns to idle, a query walks its row.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.accept) begin
                    n_state = (i_stat.kind == KIND_QUERY) ? S_QROW : S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            S_QROW: begin
                n_state = i_stat.row_stop ? S_PUT : S_QCMP;
            end
            S_QCMP: begin
                if (i_stat.cmp_stop) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Controls decoded from the state.
    always_comb begin
        o_ctrl           = '0;
        o_ctrl.ready     = (r_state == S_IDLE);
        o_ctrl.ld_commit = (r_state == S_LOAD);
        o_ctrl.q_row     = (r_state == S_QROW);
        o_ctrl.q_cmp     = (r_state == S_QCMP);
        o_ctrl.put       = (r_state == S_PUT) && i_stat.out_free;
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

@@ design/threshold_sparse_matrix_store_top.sv @@
// Threshold sparse matrix store.
// Input words (s_axis) are loads or queries, chosen by tuser. Loads carry one
// dense cell in row-major order; cells at or above keep_threshold are packed
// into compressed sparse rows. A load at row 0, column 0 starts a new matrix.
// A query names a row and column and returns one output word (m_axis) with
// the stored value and a status: hit, absent, or out of range. Loads give no
// output word. The overflow bit reports cells dropped on a full store.
// Sequence: the block takes no new word until the current one is finished.
// A load is accepted, then committed by the row-table read-modify-write.
// A query is accepted, its row-table entry is read, and its row entries are
// compared one per cycle through the single column comparator and the entry
// memory read port until the result goes to the output register; no entries
// are compared for out-of-range or empty rows.
// Reset clears the sequencer, fill pointer, overflow flag and configuration;
// the stores are not cleared, and a row must be started before it is queried.
// The output word sits in its own register: while the receiver stalls, loads
// keep being taken, and a later query waits until that register is free.
// Users write configuration via i_cfg_* while the block is idle; unenforced.
`default_nettype none

module threshold_sparse_matrix_store_top #(
    parameter int MAX_DIM     = tsms_pkg::DEF_MAX_DIM,
    parameter int MAX_ENTRIES = tsms_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [tsms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tsms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: row [9:0], col [19:10], cell_value [35:20], zeros above.
    input  wire logic [tsms_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: kind (0 load, 1 query).
    input  wire logic                                s_axis_tuser,
    // Output stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: found_value [15:0].
    output logic [tsms_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    // tuser: status [1:0], overflowed [2].
    output logic [tsms_pkg::M_TUSER_W-1:0]           m_axis_tuser
);

    import tsms_pkg::*;

    localparam int FP_W  = $clog2(MAX_ENTRIES + 1);
    localparam int EA_W  = $clog2(MAX_ENTRIES);
    localparam int RA_W  = $clog2(MAX_DIM);
    localparam int RW_W  = FP_W + LEN_W;
    localparam int EW_W  = COL_W + VAL_W;

    localparam logic [FP_W-1:0] FP_FULL = FP_W'(MAX_ENTRIES);

    // Configuration registers.
    logic [CNT_W-1:0] r_row_cnt;
    logic [CNT_W-1:0] r_col_cnt;
    logic [THR_W-1:0] r_thr;

    // Accepted word.
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [VAL_W-1:0] r_val;

    // Store state.
    logic [FP_W-1:0]  r_fp;
    logic             r_ovf;

    // Scan state.
    logic [FP_W-1:0]  r_idx;
    logic [LEN_W-1:0] r_rem;
    logic [VAL_W-1:0] r_found;
    t_status          r_status;

    // Output register.
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_found;
    t_status          r_out_status;
    logic             r_out_ovf;

    t_seq_stat        w_stat;
    t_seq_ctrl        w_ctrl;
    t_state           w_state;

    logic             w_accept;
    logic [ROW_W-1:0] w_in_row;
    logic [COL_W-1:0] w_in_col;
    logic [VAL_W-1:0] w_in_val;
    logic [31:0]      w_in_row_ext;
    logic [31:0]      w_row_ext;
    logic             w_in_range;

    logic [RW_W-1:0]  w_row_rdata;
    logic [FP_W-1:0]  w_row_start;
    logic [LEN_W-1:0] w_row_len;
    logic             w_row_we;
    logic [RW_W-1:0]  w_row_wdata;

    logic [FP_W-1:0]  w_ld_start;
    logic [LEN_W-1:0] w_ld_len;
    logic [LEN_W-1:0] w_ld_len_nx;
    logic             w_keep;
    logic             w_full;
    logic             w_append;

    logic [EW_W-1:0]  w_ent_rdata;
    logic [COL_W-1:0] w_ent_col;
    logic [VAL_W-1:0] w_ent_val;
    logic [FP_W-1:0]  w_idx_nx;
    logic             w_ent_re;
    logic [EA_W-1:0]  w_ent_raddr;
    logic             w_col_ge;
    logic             w_col_eq;

    // Input word fields and handshake.
    assign w_in_row     = s_axis_tdata[ROW_W-1:0];
    assign w_in_col     = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign w_in_val     = s_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
    assign s_axis_tready = w_ctrl.ready;
    assign w_accept     = s_axis_tvalid && w_ctrl.ready;

    assign w_in_row_ext = 32'(w_in_row);
    assign w_row_ext    = 32'(r_row);

    // Range check of the accepted cell.
    assign w_in_range = (CNT_W'(r_row) < r_row_cnt) && (w_row_ext < MAX_DIM)
                      && (CNT_W'(r_col) < r_col_cnt);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= RST_ROW_COUNT;
            r_col_cnt <= RST_COL_COUNT;
            r_thr     <= RST_KEEP_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:      r_row_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_COL_COUNT:      r_col_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_KEEP_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture of the accepted word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= w_in_row;
            r_col <= w_in_col;
            r_val <= w_in_val;
        end
    end

    // Row table: start offset and entry count of each row.
    assign w_row_start = w_row_rdata[RW_W-1:LEN_W];
    assign w_row_len   = w_row_rdata[LEN_W-1:0];

    tsms_ram #(
        .WIDTH (RW_W),
        .DEPTH (MAX_DIM)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_ext[RA_W-1:0]),
        .i_wdata (w_row_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_row_ext[RA_W-1:0]),
        .o_rdata (w_row_rdata)
    );

    // Load commit: column 0 restarts the row, kept cells are appended.
    assign w_ld_start  = (r_col == '0) ? r_fp : w_row_start;
    assign w_ld_len    = (r_col == '0) ? '0 : w_row_len;
    assign w_ld_len_nx = (w_ld_len == LEN_MAX) ? w_ld_len : w_ld_len + LEN_W'(1);
    assign w_keep      = (r_val >= r_thr);
    assign w_full      = (r_fp == FP_FULL);
    assign w_append    = w_in_range && w_keep && !w_full;
    assign w_row_we    = w_ctrl.ld_commit && w_in_range && ((r_col == '0) || w_append);
    assign w_row_wdata = {w_ld_start, w_append ? w_ld_len_nx : w_ld_len};

    // Fill pointer and sticky overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp  <= '0;
            r_ovf <= 1'b0;
        end else if (w_accept && (s_axis_tuser == KIND_LOAD)
                     && (w_in_row == '0) && (w_in_col == '0)) begin
            r_fp  <= '0;
            r_ovf <= 1'b0;
        end else if (w_ctrl.ld_commit) begin
            if (w_append) begin
                r_fp <= r_fp + FP_W'(1);
            end
            if (w_in_range && w_keep && w_full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Entry store: column in the upper bits, value in the lower bits.
    assign w_ent_col = w_ent_rdata[EW_W-1:VAL_W];
    assign w_ent_val = w_ent_rdata[VAL_W-1:0];

    tsms_ram #(
        .WIDTH (EW_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.ld_commit && w_append),
        .i_waddr (r_fp[EA_W-1:0]),
        .i_wdata ({r_col, r_val}),
        .i_re    (w_ent_re),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    // Scan: one stored column compared against the query column per cycle.
    assign w_col_ge = (w_ent_col >= r_col);
    assign w_col_eq = (w_ent_col == r_col);
    assign w_idx_nx = r_idx + FP_W'(1);

    assign w_stat.accept   = w_accept;
    assign w_stat.kind     = s_axis_tuser;
    assign w_stat.row_stop = !w_in_range || (w_row_len == '0) || (w_row_start >= FP_FULL);
    assign w_stat.cmp_stop = w_col_ge || (r_rem == LEN_W'(1)) || (w_idx_nx >= FP_FULL);
    assign w_stat.out_free = !r_out_valid || m_axis_tready;

    assign w_ent_re    = (w_ctrl.q_row && !w_stat.row_stop)
                       || (w_ctrl.q_cmp && !w_stat.cmp_stop);
    assign w_ent_raddr = w_ctrl.q_row ? w_row_start[EA_W-1:0] : w_idx_nx[EA_W-1:0];

    // Scan position and lookup result.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.q_row) begin
            r_idx    <= w_row_start;
            r_rem    <= w_row_len;
            r_found  <= '0;
            r_status <= w_in_range ? ST_ABSENT : ST_RANGE;
        end else if (w_ctrl.q_cmp) begin
            r_idx <= w_idx_nx;
            r_rem <= r_rem - LEN_W'(1);
            if (w_col_ge && w_col_eq) begin
                r_found  <= w_ent_val;
                r_status <= ST_HIT;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.put) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.put) begin
            r_out_found  <= r_found;
            r_out_status <= r_status;
            r_out_ovf    <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_found;
    assign m_axis_tuser  = {r_out_ovf, r_out_status};

    // Sequencer.
    tsms_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_state (w_state)
    );

`ifndef SYNTH
    // The fill pointer never passes the store size.
    a_fp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fp <= FP_FULL)
        else $error("fill pointer beyond store size");

    // The fill pointer only steps by one or restarts at zero.
    a_fp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fp != $past(r_fp)))
        |-> ((r_fp == $past(r_fp) + FP_W'(1)) || (r_fp == '0)))
        else $error("fill pointer jumped");

    // Overflow is only flagged while the store is full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> ($past(r_fp) == FP_FULL))
        else $error("overflow flagged with room left");

    // A result word only comes out of a finished lookup.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_state == S_PUT))
        else $error("result word without a lookup");
`endif

endmodule

`default_nettype wire

@@ tb/sv/threshold_sparse_matrix_store_top_tb.sv @@
module threshold_sparse_matrix_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsms_pkg::*;

    // One input word as the generator sees it.
    typedef struct packed {
        logic             kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_cell_word;

    // One lookup answer.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
        logic             overflowed;
    } t_lookup;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: row [9:0], col [19:10], cell_value [35:20], zeros above.
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: kind.
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: found_value [15:0].
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // tuser: status [1:0], overflowed [2].
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    threshold_sparse_matrix_store_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mirror of the compressed matrix and its configuration.
    logic [VAL_W-1:0] kept_value [DEF_MAX_ENTRIES];
    logic [COL_W-1:0] kept_col   [DEF_MAX_ENTRIES];
    logic [12:0]      row_base   [DEF_MAX_DIM];
    logic [LEN_W-1:0] row_len    [DEF_MAX_DIM];
    logic [12:0]      fill_ptr = '0;
    logic             full_flag = 1'b0;
    logic [CNT_W-1:0] cfg_rows = RST_ROW_COUNT;
    logic [CNT_W-1:0] cfg_cols = RST_COL_COUNT;
    logic [THR_W-1:0] cfg_thresh = RST_KEEP_THRESHOLD;

    // Words waiting to be sent and answers waiting to arrive.
    t_cell_word pending_words[$];
    t_lookup    expected_lookups[$];

    // Generator view: current settings and rows whose start has been queued.
    int  gen_rows = 1024;
    int  gen_cols = 1024;
    int  gen_thr = 328;
    int  q_rows = 1;
    int  q_cols = 1;
    bit  gen_row_open [DEF_MAX_DIM];

    int  words_pushed = 0;
    int  words_taken = 0;
    bit  word_sent = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_req = 1'b0;
    int  hold_cycles = 0;
    bit  rx_ready = 1'b0;
    int  rx_left = 0;

    int  errors = 0;
    int  n_loads = 0;
    int  n_queries = 0;
    int  n_hits = 0;
    int  n_absent = 0;
    int  n_range = 0;
    int  n_full = 0;
    int  n_configs = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    // Apply one accepted load to the mirror.
    task automatic store_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                              input logic [VAL_W-1:0] v);
        if (r == 0 && c == 0) begin
            fill_ptr = '0;
            full_flag = 1'b0;
        end
        if (r < cfg_rows && c < cfg_cols) begin
            if (c == 0) begin
                row_base[r] = fill_ptr;
                row_len[r] = '0;
            end
            if (v >= cfg_thresh) begin
                if (fill_ptr >= DEF_MAX_ENTRIES) begin
                    full_flag = 1'b1;
                end else begin
                    kept_value[fill_ptr] = v;
                    kept_col[fill_ptr] = c;
                    fill_ptr = fill_ptr + 1'b1;
                    if (row_len[r] != LEN_MAX)
                        row_len[r] = row_len[r] + 1'b1;
                end
            end
        end
    endtask

    // Scan a row's entries in stored order for the queried column.
    function automatic t_lookup lookup_cell(input logic [ROW_W-1:0] r,
                                            input logic [COL_W-1:0] c);
        t_lookup res;
        int      idx;
        res.value = '0;
        res.status = ST_ABSENT;
        res.overflowed = full_flag;
        if (!(r < cfg_rows && c < cfg_cols)) begin
            res.status = ST_RANGE;
        end else begin
            for (int i = 0; i < row_len[r]; i++) begin
                idx = row_base[r] + i;
                if (idx >= DEF_MAX_ENTRIES)
                    break;
                if (kept_col[idx] >= c) begin
                    if (kept_col[idx] == c) begin
                        res.value = kept_value[idx];
                        res.status = ST_HIT;
                    end
                    break;
                end
            end
        end
        return res;
    endfunction

    // Compare one output word with the oldest expected answer.
    task automatic check_lookup();
        t_lookup exp_res;
        if (expected_lookups.size() == 0) begin
            errors++;
            $display("%0t: output word with no lookup pending: value %h tuser %b",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
            exp_res = expected_lookups.pop_front();
            case (exp_res.status)
                ST_HIT:    n_hits++;
                ST_ABSENT: n_absent++;
                default:   n_range++;
            endcase
            if (exp_res.overflowed)
                n_full++;
            if (m_axis_tdata !== exp_res.value || m_axis_tuser[1:0] !== exp_res.status ||
                m_axis_tuser[2] !== exp_res.overflowed) begin
                errors++;
                $display({"%0t: lookup mismatch: expected value %h status %0d ",
                          "overflowed %b, got value %h status %0d overflowed %b"},
                         $time, exp_res.value, exp_res.status, exp_res.overflowed,
                         m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2]);
            end
        end
    endtask

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_lookup();
            if (s_axis_tvalid && s_axis_tready) begin
                words_taken++;
                word_sent = 1'b1;
                if (s_axis_tuser == KIND_QUERY) begin
                    n_queries++;
                    expected_lookups = {expected_lookups,
                                        lookup_cell(s_axis_tdata[9:0], s_axis_tdata[19:10])};
                end else begin
                    n_loads++;
                    store_cell(s_axis_tdata[9:0], s_axis_tdata[19:10], s_axis_tdata[35:20]);
                end
            end
        end
    end

    // Sender: bursts of words with random gaps in between.
    always @(negedge i_clk) begin : feed
        t_cell_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !word_sent) begin
            // Hold the word until it is taken.
        end else begin
            word_sent = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, w.value, w.col, w.row};
                s_axis_tuser <= w.kind;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: alternating ready and stall runs, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cycles = 400;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_ready = ~rx_ready;
                if (rx_ready)
                    rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 20);
                else
                    rx_left = $urandom_range(1, 6);
            end
            rx_left--;
            m_axis_tready <= rx_ready;
        end
    end

    // Queue one word; a load at column 0 of an in-range row opens that row.
    task automatic push_word(input logic kind, input int r, input int c, input int v);
        t_cell_word w;
        w.kind = kind;
        w.row = ROW_W'(r);
        w.col = COL_W'(c);
        w.value = VAL_W'(v);
        pending_words = {pending_words, w};
        words_pushed++;
        if (kind == KIND_LOAD && c == 0 && r < gen_rows && c < gen_cols)
            gen_row_open[r] = 1'b1;
    endtask

    // Cell values cluster at the threshold and the ends of the range.
    function automatic int pick_value();
        int v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 32768;
            2, 3: v = gen_thr + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(0, 32768);
        endcase
        if (v < 0)
            v = 0;
        if (v > 32768)
            v = 32768;
        return v;
    endfunction

    // Queue a query: mostly into opened rows, sometimes out of range.
    task automatic push_query();
        int r;
        int c;
        if ($urandom_range(0, 7) == 0 && (gen_rows < 1024 || gen_cols < 1024)) begin
            if (gen_rows < 1024 && (gen_cols == 1024 || $urandom_range(0, 1) == 0))
                push_word(KIND_QUERY, $urandom_range(gen_rows, 1023), $urandom_range(0, 1023), 0);
            else
                push_word(KIND_QUERY, $urandom_range(0, 1023), $urandom_range(gen_cols, 1023), 0);
        end else begin
            for (int t = 0; t < 8; t++) begin
                r = $urandom_range(0, q_rows - 1);
                c = $urandom_range(0, q_cols - 1);
                if (r < gen_rows && gen_row_open[r]) begin
                    push_word(KIND_QUERY, r, c, $urandom_range(0, 65535));
                    break;
                end
            end
        end
    endtask

    // Stream a dense matrix in row-major order with a little noise mixed in.
    task automatic build_matrix(input int nr, input int nc);
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                push_word(KIND_LOAD, r, c, pick_value());
                case ($urandom_range(0, 19))
                    0: push_query();
                    1: begin
                        if (gen_rows < 1024)
                            push_word(KIND_LOAD, $urandom_range(gen_rows, 1023),
                                      $urandom_range(0, 1023), pick_value());
                        else if (gen_cols < 1024)
                            push_word(KIND_LOAD, r, $urandom_range(gen_cols, 1023),
                                      pick_value());
                    end
                    2: push_word(KIND_LOAD, r, $urandom_range(0, nc - 1), pick_value());
                    default: ;
                endcase
            end
        end
    endtask

    // Write all three registers; only called while the block is idle.
    task automatic set_config(input int rows, input int cols, input int thr);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data <= CFG_DATA_W'(rows);
        cfg_rows = CNT_W'(rows);
        @(negedge i_clk);
        i_cfg_index <= CFG_COL_COUNT;
        i_cfg_data <= CFG_DATA_W'(cols);
        cfg_cols = CNT_W'(cols);
        @(negedge i_clk);
        i_cfg_index <= CFG_KEEP_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(thr);
        cfg_thresh = THR_W'(thr);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gen_rows = rows;
        gen_cols = cols;
        gen_thr = thr;
        n_configs++;
    endtask

    // Wait until every word is taken and every answer has come back.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (words_taken != words_pushed || expected_lookups.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int random_start;
        int nr;
        int nc;
        int rows;
        int cols;
        int thr;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed: threshold edges, end columns and rows, an out-of-order append.
        push_word(KIND_LOAD, 0, 0, 32768);
        push_word(KIND_LOAD, 0, 1, 327);
        push_word(KIND_LOAD, 0, 2, 328);
        push_word(KIND_LOAD, 0, 3, 0);
        push_word(KIND_LOAD, 0, 1023, 1000);
        push_word(KIND_LOAD, 1, 0, 329);
        push_word(KIND_LOAD, 1, 5, 0);
        push_word(KIND_LOAD, 1023, 0, 32768);
        push_word(KIND_LOAD, 1023, 1023, 500);
        push_word(KIND_LOAD, 1023, 7, 400);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_QUERY, 0, 1, 0);
        push_word(KIND_QUERY, 0, 2, 0);
        push_word(KIND_QUERY, 0, 3, 0);
        push_word(KIND_QUERY, 0, 1023, 0);
        push_word(KIND_QUERY, 1, 0, 0);
        push_word(KIND_QUERY, 1, 5, 0);
        push_word(KIND_QUERY, 1023, 1023, 65535);
        push_word(KIND_QUERY, 1023, 7, 0);
        wait_idle();

        // Long receiver hold-off while queries keep coming, so the input stalls.
        hold_req = 1'b1;
        repeat (30) begin
            case ($urandom_range(0, 2))
                0: push_word(KIND_QUERY, 0, $urandom_range(0, 1023), 0);
                1: push_word(KIND_QUERY, 1, $urandom_range(0, 7), 0);
                default: push_word(KIND_QUERY, 1023, $urandom_range(0, 1023), 0);
            endcase
        end
        wait_idle();

        // Out-of-range loads are ignored and out-of-range queries report it.
        set_config(2, 3, 328);
        push_word(KIND_LOAD, 2, 0, 5000);
        push_word(KIND_LOAD, 0, 3, 5000);
        push_word(KIND_QUERY, 2, 0, 0);
        push_word(KIND_QUERY, 0, 3, 0);
        push_word(KIND_QUERY, 1, 0, 0);
        wait_idle();

        // Random matrices of small size under varied settings.
        random_start = words_pushed;
        while (words_pushed - random_start < 480) begin
            nr = $urandom_range(1, 6);
            nc = $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0: rows = nr;
                1: rows = nr + $urandom_range(1, 3);
                default: rows = 1024;
            endcase
            case ($urandom_range(0, 2))
                0: cols = nc;
                1: cols = nc + $urandom_range(1, 3);
                default: cols = 1024;
            endcase
            case ($urandom_range(0, 4))
                0: thr = 0;
                1: thr = 32768;
                2: thr = 328;
                3: thr = $urandom_range(0, 2000);
                default: thr = $urandom_range(0, 32768);
            endcase
            set_config(rows, cols, thr);
            q_rows = nr;
            q_cols = nc;
            build_matrix(nr, nc);
            repeat (nr * nc / 2 + 4) push_query();
            wait_idle();
        end

        // Largest dimensions with the highest threshold: the first and the last row.
        set_config(1024, 1024, 32768);
        for (int c = 0; c < 4; c++)
            push_word(KIND_LOAD, 0, c, pick_value());
        push_word(KIND_LOAD, 1023, 0, 32768);
        for (int c = 1; c < 1024; c += $urandom_range(1, 50))
            push_word(KIND_LOAD, 1023, c, ($urandom_range(0, 1) == 0) ? 32768 : pick_value());
        push_word(KIND_LOAD, 1023, 1023, 32768);
        repeat (30)
            push_word(KIND_QUERY, ($urandom_range(0, 1) == 0) ? 0 : 1023,
                      $urandom_range(0, 1023), 0);
        wait_idle();

        // Smallest dimensions with a zero threshold.
        set_config(1, 1, 0);
        push_word(KIND_LOAD, 0, 0, 0);
        push_word(KIND_LOAD, 0, 1, 77);
        push_word(KIND_LOAD, 5, 0, 77);
        push_word(KIND_QUERY, 0, 0, 0);
        push_word(KIND_QUERY, 1, 0, 0);
        push_word(KIND_QUERY, 0, 1, 0);
        push_word(KIND_QUERY, 1023, 1023, 0);
        wait_idle();

        repeat (20) @(negedge i_clk);
        if (expected_lookups.size() != 0) begin
            errors++;
            $display("%0t: %0d lookups never answered", $time, expected_lookups.size());
        end
        $display("Run covered %0d loads and %0d queries over %0d register settings.",
                 n_loads, n_queries, n_configs);
        $display({"Lookups: %0d hits, %0d absent, %0d out of range, ",
                  "%0d with overflow; %0d errors."},
                 n_hits, n_absent, n_range, n_full, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ threshold_sparse_matrix_store_top.f @@
design/tsms_pkg.sv
design/tsms_ram.sv
design/tsms_seq.sv
design/threshold_sparse_matrix_store_top.sv
tb/sv/threshold_sparse_matrix_store_top_tb.sv
